// ===== hw/rtl/wrs_pkg.sv =====
package wrs_pkg;

  // Default sizes
  localparam int unsigned MAX_WIDTH_DEF = 32;
  localparam int unsigned WAVE_BITS_DEF = 16;

  // Frame height limit and field widths of the registers
  localparam int unsigned MAX_HEIGHT  = 4096;
  localparam int unsigned ROW_W       = 12;
  localparam int unsigned GW_W        = 6;
  localparam int unsigned GH_W        = 13;
  localparam int unsigned LS_W        = 4;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned CFG_IDX_W   = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_SHIFT  = 2'd2;

  // Register reset values
  localparam logic [GW_W-1:0] GRID_WIDTH_RST  = 6'd32;
  localparam logic [GH_W-1:0] GRID_HEIGHT_RST = 13'd32;
  localparam logic [LS_W-1:0] LOSS_SHIFT_RST  = 4'd4;

  // Which of the four neighbors lie inside the grid
  typedef struct packed {
    logic has_left;
    logic has_right;
    logic has_up;
    logic has_down;
  } nb_mask_t;

endpackage

// ===== hw/rtl/wave_ripple_step.sv =====
// A cell's result leaves one row later: after the cell below it is accepted, it
// passes the operand stage and then the output register. Throughput: one cell per
// cycle while the output is not stalled. After a frame's last cell the row store
// drains the final row at one result per cycle unless stalled, and no input is
// taken for those cycles. Reset: counters and pipeline valids clear, registers take
// their defaults; row stores are not cleared, and unwritten entries read are masked.
module wave_ripple_step #(
  parameter int unsigned MAX_WIDTH = wrs_pkg::MAX_WIDTH_DEF,
  parameter int unsigned WAVE_BITS = wrs_pkg::WAVE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [wrs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wrs_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // input cells
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [WAVE_BITS-1:0]        cur_wave_i,
  input  logic signed [WAVE_BITS-1:0]        prev_wave_i,
  // results
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [WAVE_BITS-1:0]        next_wave_o,
  output logic signed [WAVE_BITS-1:0]        held_wave_o,
  output logic                               frame_end_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned EW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW    = wrs_pkg::ROW_W;
  localparam int unsigned HW    = wrs_pkg::GH_W;

  // Configuration registers
  logic [wrs_pkg::GW_W-1:0] grid_width_q;
  logic [HW-1:0]            grid_height_q;
  logic [wrs_pkg::LS_W-1:0] loss_shift_q;
  logic                     cfg_hit;

  // Position counters and drain sequencer
  logic [COL_W-1:0] col_q;
  logic [RW-1:0]    row_q;
  logic             flush_q;
  logic [COL_W-1:0] fcol_q;
  logic             fpar_q;
  logic             fup_q;

  // Row stores and first-column holder
  logic signed [WAVE_BITS-1:0] bank0_mem [MAX_WIDTH];
  logic signed [WAVE_BITS-1:0] bank1_mem [MAX_WIDTH];
  logic signed [WAVE_BITS-1:0] prev_mem  [MAX_WIDTH];
  logic signed [WAVE_BITS-1:0] first_q;

  // Operand stage
  logic                        s1_valid_q;
  logic                        s1_par_q;
  logic                        s1_fe_q;
  wrs_pkg::nb_mask_t           s1_mask_q;
  logic signed [WAVE_BITS-1:0] left_q;
  logic signed [WAVE_BITS-1:0] center_q;
  logic signed [WAVE_BITS-1:0] down_q;
  logic signed [WAVE_BITS-1:0] rd0_q;
  logic signed [WAVE_BITS-1:0] rd1_q;
  logic signed [WAVE_BITS-1:0] prv_q;
  logic signed [WAVE_BITS-1:0] right_w;
  logic signed [WAVE_BITS-1:0] up_w;

  // Result register
  logic                        out_valid_q;
  logic signed [WAVE_BITS-1:0] next_q;
  logic signed [WAVE_BITS-1:0] held_q;
  logic                        fe_q;
  logic signed [WAVE_BITS-1:0] next_w;

  // Control
  logic [EW-1:0]     eff_w;
  logic [HW-1:0]     eff_h;
  logic [COL_W-1:0]  x_c;
  logic [RW-1:0]     r_c;
  logic              col_last;
  logic              frame_last;
  logic              in_fire;
  logic              out_load;
  logic              s1_en;
  logic              s1_load;
  logic [COL_W-1:0]  e_col;
  logic [COL_W-1:0]  e_next;
  logic              e_par;
  logic              e_fe;
  wrs_pkg::nb_mask_t e_mask;
  logic [COL_W-1:0]  addr0;
  logic [COL_W-1:0]  addr1;

  // Effective frame size
  always_comb begin
    if (grid_width_q == '0) begin
      eff_w = EW'(1);
    end else if (grid_width_q > wrs_pkg::GW_W'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(grid_width_q);
    end
    if (grid_height_q == '0) begin
      eff_h = HW'(1);
    end else if (grid_height_q > HW'(wrs_pkg::MAX_HEIGHT)) begin
      eff_h = HW'(wrs_pkg::MAX_HEIGHT);
    end else begin
      eff_h = grid_height_q;
    end
  end

  // Current cell position, restarting if outside the frame
  always_comb begin
    if ((EW'(col_q) >= eff_w) || (HW'(row_q) >= eff_h)) begin
      x_c = '0;
      r_c = '0;
    end else begin
      x_c = col_q;
      r_c = row_q;
    end
    col_last   = (EW'(x_c) + EW'(1)) == eff_w;
    frame_last = col_last && ((HW'(r_c) + HW'(1)) == eff_h);
  end

  // Handshakes
  assign out_load   = s1_valid_q && (!out_valid_q || out_ready_i);
  assign s1_en      = !s1_valid_q || out_load;
  assign in_ready_o = s1_en && !flush_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign s1_load    = (in_fire && (r_c != '0)) || (flush_q && s1_en);

  // Select the cell to emit: the lagged cell above the input, or a drain cell
  always_comb begin
    if (flush_q) begin
      e_col           = fcol_q;
      e_par           = fpar_q;
      e_mask.has_up   = fup_q;
      e_mask.has_down = 1'b0;
      e_fe            = (EW'(fcol_q) + EW'(1)) == eff_w;
    end else begin
      e_col           = x_c;
      e_par           = ~r_c[0];
      e_mask.has_up   = r_c > RW'(1);
      e_mask.has_down = 1'b1;
      e_fe            = 1'b0;
    end
    e_mask.has_left  = e_col != '0;
    e_mask.has_right = (EW'(e_col) + EW'(1)) != eff_w;
    e_next = (e_col == COL_W'(MAX_WIDTH - 1)) ? '0 : e_col + COL_W'(1);
    // right neighbor from the emitted row's bank, upper row from the other
    addr0 = e_par ? e_col : e_next;
    addr1 = e_par ? e_next : e_col;
  end

  // Writes to the grid width, grid height and loss shift registers restart the frame
  assign cfg_hit = cfg_we_i && ((cfg_idx_i == wrs_pkg::CFG_GRID_WIDTH) ||
                                (cfg_idx_i == wrs_pkg::CFG_GRID_HEIGHT) ||
                                (cfg_idx_i == wrs_pkg::CFG_LOSS_SHIFT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= wrs_pkg::GRID_WIDTH_RST;
      grid_height_q <= wrs_pkg::GRID_HEIGHT_RST;
      loss_shift_q  <= wrs_pkg::LOSS_SHIFT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wrs_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i[wrs_pkg::GW_W-1:0];
        wrs_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_wdata_i[HW-1:0];
        wrs_pkg::CFG_LOSS_SHIFT:  loss_shift_q  <= cfg_wdata_i[wrs_pkg::LS_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the position counters and run the drain of the last row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      flush_q <= 1'b0;
      fcol_q  <= '0;
      fpar_q  <= 1'b0;
      fup_q   <= 1'b0;
    end else if (cfg_hit) begin
      col_q   <= '0;
      row_q   <= '0;
      flush_q <= 1'b0;
    end else if (in_fire) begin
      if (frame_last) begin
        col_q   <= '0;
        row_q   <= '0;
        flush_q <= 1'b1;
        fcol_q  <= '0;
        fpar_q  <= r_c[0];
        fup_q   <= r_c != '0;
      end else if (col_last) begin
        col_q <= '0;
        row_q <= r_c + RW'(1);
      end else begin
        col_q <= x_c + COL_W'(1);
        row_q <= r_c;
      end
    end else if (flush_q && s1_en) begin
      if (e_fe) begin
        flush_q <= 1'b0;
      end else begin
        fcol_q <= fcol_q + COL_W'(1);
      end
    end
  end

  // Row stores: read before write at the same address
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      rd0_q <= bank0_mem[addr0];
    end
    if (in_fire && !r_c[0]) begin
      bank0_mem[x_c] <= cur_wave_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      rd1_q <= bank1_mem[addr1];
    end
    if (in_fire && r_c[0]) begin
      bank1_mem[x_c] <= cur_wave_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      prv_q <= prev_mem[e_col];
    end
    if (in_fire) begin
      prev_mem[x_c] <= prev_wave_i;
    end
  end

  // Hold the first cell of the newest row; the window starts from it
  always_ff @(posedge clk_i) begin
    if (in_fire && (x_c == '0)) begin
      first_q <= cur_wave_i;
    end
  end

  assign right_w = s1_par_q ? rd1_q : rd0_q;
  assign up_w    = s1_par_q ? rd0_q : rd1_q;

  // Operand stage: slide the window along the emitted row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= 1'b1;
    end else if (out_load) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_par_q  <= e_par;
      s1_fe_q   <= e_fe;
      s1_mask_q <= e_mask;
      left_q    <= center_q;
      center_q  <= (e_col == '0) ? first_q : right_w;
      down_q    <= cur_wave_i;
    end
  end

  wrs_damp #(
    .WAVE_BITS (WAVE_BITS)
  ) u_damp (
    .left_i       (left_q),
    .right_i      (right_w),
    .up_i         (up_w),
    .down_i       (down_q),
    .prev_i       (prv_q),
    .mask_i       (s1_mask_q),
    .loss_shift_i (loss_shift_q),
    .next_wave_o  (next_w)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      next_q <= next_w;
      held_q <= center_q;
      fe_q   <= s1_fe_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign next_wave_o = next_q;
  assign held_wave_o = held_q;
  assign frame_end_o = fe_q;

endmodule

// ===== hw/rtl/wrs_damp.sv =====
module wrs_damp #(
  parameter int unsigned WAVE_BITS = wrs_pkg::WAVE_BITS_DEF
) (
  input  logic signed [WAVE_BITS-1:0]  left_i,
  input  logic signed [WAVE_BITS-1:0]  right_i,
  input  logic signed [WAVE_BITS-1:0]  up_i,
  input  logic signed [WAVE_BITS-1:0]  down_i,
  input  logic signed [WAVE_BITS-1:0]  prev_i,
  input  wrs_pkg::nb_mask_t            mask_i,
  input  logic [wrs_pkg::LS_W-1:0]     loss_shift_i,
  output logic signed [WAVE_BITS-1:0]  next_wave_o
);

  localparam int unsigned SW = WAVE_BITS + 3;
  localparam logic signed [SW-1:0] WMAX = SW'((64'sd1 <<< (WAVE_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] WMIN = -WMAX - SW'(1);

  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] rnd;
  logic signed [SW-1:0] half;
  logic signed [SW-1:0] v;
  logic signed [SW-1:0] lost;
  logic signed [SW-1:0] damped;

  // Sum the in-grid neighbors, halve toward zero, subtract the previous height
  always_comb begin
    sum = (mask_i.has_left  ? SW'(left_i)  : '0)
        + (mask_i.has_right ? SW'(right_i) : '0)
        + (mask_i.has_up    ? SW'(up_i)    : '0)
        + (mask_i.has_down  ? SW'(down_i)  : '0);
    rnd  = $signed({{(SW-1){1'b0}}, sum[SW-1]});
    half = (sum + rnd) >>> 1;
    v    = half - SW'(prev_i);
  end

  // Damp by the floored shifted fraction, then saturate
  always_comb begin
    lost   = v >>> loss_shift_i;
    damped = v - lost;
    if (damped > WMAX) begin
      next_wave_o = WMAX[WAVE_BITS-1:0];
    end else if (damped < WMIN) begin
      next_wave_o = WMIN[WAVE_BITS-1:0];
    end else begin
      next_wave_o = damped[WAVE_BITS-1:0];
    end
  end

endmodule
